/* hw/rtl/fhe_pkg.sv */
// shared widths, types, sine/cosine table and helpers of the fundamental extractor
package fhe_pkg;

	localparam int WINDOW_LEN = 400;
	localparam int SAMPLE_BITS = 16;
	localparam int PH_W = $clog2(WINDOW_LEN);
	localparam int ROM_W = 16;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int UPD_W = DIFF_W + ROM_W;
	localparam int SUM_W = SAMPLE_BITS + ROM_W - 1 + PH_W;
	localparam int PROD_W = SUM_W + ROM_W;
	localparam int RND_W = PROD_W + 2;
	// q15 times q15 gives q30, the factor 2 of 2/n takes one more bit off
	localparam int FRAC_SH = 2 * (ROM_W - 1) - 1;
	localparam int T_W = RND_W - FRAC_SH;
	localparam int U_W = T_W - 1;
	localparam int DIV_SH = U_W + PH_W;
	localparam int DIV_M_W = U_W + 2;
	localparam int MUL_W = U_W + DIV_M_W;
	localparam logic [63:0] DIV_M64 =
		((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
	localparam logic [DIV_M_W-1:0] DIV_M = DIV_M64[DIV_M_W-1:0];
	localparam int Q_W = U_W - PH_W + 2;
	localparam int F_W = Q_W + 1;
	localparam int H_W = F_W + 1;
	localparam logic [63:0] RND_HALF64 = 64'(WINDOW_LEN) << (FRAC_SH - 1);
	localparam logic signed [RND_W-1:0] RND_HALF = RND_HALF64[RND_W-1:0];
	localparam int SAT_HI = 2 ** (SAMPLE_BITS - 1) - 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	typedef logic [2*ROM_W-1:0] rom_tab_t [WINDOW_LEN];

	// one queued word: sample, new minus old, and the table pair at its phase
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [DIFF_W-1:0] diff;
		logic signed [ROM_W-1:0] s;
		logic signed [ROM_W-1:0] c;
	} work_t;

	// q30 taylor series on [0, pi/2): odd selects sine, else cosine
	function automatic logic [63:0] series_q30(input logic [63:0] x, input logic odd);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] acc;
		x2 = (x * x) >> 30;
		if (odd) begin
			term = x;
			acc = signed'(term);
			term = ((term * x2) >> 30) / 64'd6;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd20;
			acc = acc + signed'(term);
			term = ((term * x2) >> 30) / 64'd42;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd72;
			acc = acc + signed'(term);
			term = ((term * x2) >> 30) / 64'd110;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd156;
			acc = acc + signed'(term);
			term = ((term * x2) >> 30) / 64'd210;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd272;
			acc = acc + signed'(term);
		end else begin
			term = ONE_Q30;
			acc = signed'(term);
			term = ((term * x2) >> 30) / 64'd2;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd12;
			acc = acc + signed'(term);
			term = ((term * x2) >> 30) / 64'd30;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd56;
			acc = acc + signed'(term);
			term = ((term * x2) >> 30) / 64'd90;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd132;
			acc = acc + signed'(term);
			term = ((term * x2) >> 30) / 64'd182;
			acc = acc - signed'(term);
			term = ((term * x2) >> 30) / 64'd240;
			acc = acc + signed'(term);
		end
		if (acc < 0) begin
			acc = '0;
		end
		return unsigned'(acc);
	endfunction

	function automatic logic signed [ROM_W-1:0] q30_to_q15(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[ROM_W-1:0];
	endfunction

	// {sin, cos} of entry k by quadrant folding
	function automatic logic [2*ROM_W-1:0] rom_entry(input int unsigned k);
		logic [63:0] r4;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] x;
		logic signed [ROM_W-1:0] s;
		logic signed [ROM_W-1:0] c;
		logic [2*ROM_W-1:0] e;
		r4 = 64'(k) << 2;
		quad = r4 / 64'(WINDOW_LEN);
		rem = r4 % 64'(WINDOW_LEN);
		x = (HALF_PI_Q30 * rem) / 64'(WINDOW_LEN);
		s = q30_to_q15(series_q30(x, 1'b1));
		c = q30_to_q15(series_q30(x, 1'b0));
		unique case (quad[1:0])
			2'd0: e = {s, c};
			2'd1: e = {c, -s};
			2'd2: e = {-s, -c};
			2'd3: e = {-c, s};
		endcase
		return e;
	endfunction

	function automatic rom_tab_t build_rom();
		rom_tab_t t;
		for (int k = 0; k < WINDOW_LEN; k++) begin
			t[k] = rom_entry(k);
		end
		return t;
	endfunction

	localparam rom_tab_t ROM_TAB = build_rom();

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [H_W-1:0] v);
		logic signed [H_W-1:0] hi;
		logic signed [H_W-1:0] lo;
		logic signed [SAMPLE_BITS-1:0] r;
		hi = H_W'(SAT_HI);
		lo = -hi - H_W'(1);
		if (v > hi) begin
			r = hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			r = lo[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/fhe_front.sv */
// front end: accepts samples, keeps the sample ring and reads the table pair
module fhe_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [fhe_pkg::SAMPLE_BITS-1:0] sample,
	input  logic q_full,
	output logic push,
	output fhe_pkg::work_t push_data
);

	logic signed [fhe_pkg::SAMPLE_BITS-1:0] ring [fhe_pkg::WINDOW_LEN];
	logic [fhe_pkg::PH_W-1:0] phase_q;
	logic wrapped_q;
	logic valid_s1;
	logic old_ok_s1;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] x_s1;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] old_s1;
	logic [2*fhe_pkg::ROM_W-1:0] rom_s1;
	logic accept;
	logic signed [fhe_pkg::DIFF_W-1:0] old_ext;

	assign push = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign accept = in_valid && in_ready;

	// read-before-write: the read register gets the sample leaving the window
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[phase_q] <= sample;
			old_s1 <= ring[phase_q];
			rom_s1 <= fhe_pkg::ROM_TAB[phase_q];
			x_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wrapped_q <= 1'b0;
			valid_s1 <= 1'b0;
			old_ok_s1 <= 1'b0;
		end else begin
			if (accept) begin
				old_ok_s1 <= wrapped_q;
				if (phase_q == fhe_pkg::PH_W'(fhe_pkg::WINDOW_LEN - 1)) begin
					phase_q <= '0;
					wrapped_q <= 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// entries not yet written in the first pass count as zero
	assign old_ext = old_ok_s1 ? fhe_pkg::DIFF_W'(old_s1) : '0;

	always_comb begin
		push_data.x = x_s1;
		push_data.diff = fhe_pkg::DIFF_W'(x_s1) - old_ext;
		push_data.s = rom_s1[2*fhe_pkg::ROM_W-1:fhe_pkg::ROM_W];
		push_data.c = rom_s1[fhe_pkg::ROM_W-1:0];
	end

endmodule

/* hw/rtl/fhe_queue.sv */
// short queue of work words between front and back end
module fhe_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fhe_pkg::work_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output fhe_pkg::work_t head
);

	fhe_pkg::work_t mem_q [fhe_pkg::QUEUE_DEPTH];
	logic [fhe_pkg::QP_W-1:0] wr_ptr_q;
	logic [fhe_pkg::QP_W-1:0] rd_ptr_q;
	logic [fhe_pkg::QC_W-1:0] count_q;

	assign full = count_q == fhe_pkg::QC_W'(fhe_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == fhe_pkg::QP_W'(fhe_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == fhe_pkg::QP_W'(fhe_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/fhe_back.sv */
// back end: running dft sums, fundamental rebuild, rounding and output register
module fhe_back (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  fhe_pkg::work_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [fhe_pkg::SAMPLE_BITS-1:0] harmonic_ref,
	output logic signed [fhe_pkg::SAMPLE_BITS-1:0] fundamental
);

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;
	logic signed [fhe_pkg::SUM_W-1:0] sine_sum_q;
	logic signed [fhe_pkg::SUM_W-1:0] cosine_sum_q;

	logic signed [fhe_pkg::UPD_W-1:0] upd_s_s1, upd_c_s1;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic signed [fhe_pkg::ROM_W-1:0] s_s1, c_s1, s_s2, c_s2;
	logic signed [fhe_pkg::PROD_W-1:0] rs_s3, rc_s3;
	logic [fhe_pkg::U_W-1:0] u_s4;
	logic neg_s4, neg_s5;
	logic [fhe_pkg::MUL_W-1:0] dprod_s5;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] harmonic_ref_q, fundamental_q;

	logic signed [fhe_pkg::RND_W-1:0] rnd;
	logic signed [fhe_pkg::T_W-1:0] t_val;
	logic [fhe_pkg::Q_W-1:0] q_mag;
	logic signed [fhe_pkg::F_W-1:0] fund;
	logic signed [fhe_pkg::H_W-1:0] harm;

	assign en = !out_valid_q || out_ready;
	assign pop = en && !empty;

	// round half up: floor((p + d/2) / 2^29) then floor by n
	assign rnd = fhe_pkg::RND_W'(rs_s3) + fhe_pkg::RND_W'(rc_s3) + fhe_pkg::RND_HALF;
	assign t_val = rnd[fhe_pkg::RND_W-1:fhe_pkg::FRAC_SH];

	// negative quotients go through ones' complement: floor(t/n) = ~floor(~t/n)
	assign q_mag = dprod_s5[fhe_pkg::DIV_SH +: fhe_pkg::Q_W];
	assign fund = {1'b0, q_mag} ^ {fhe_pkg::F_W{neg_s5}};
	assign harm = fhe_pkg::H_W'(x_s5) - fhe_pkg::H_W'(fund);

	always_ff @(posedge clk) begin
		if (en) begin
			upd_s_s1 <= fhe_pkg::UPD_W'(head.diff) * fhe_pkg::UPD_W'(head.s);
			upd_c_s1 <= fhe_pkg::UPD_W'(head.diff) * fhe_pkg::UPD_W'(head.c);
			x_s1 <= head.x;
			s_s1 <= head.s;
			c_s1 <= head.c;

			x_s2 <= x_s1;
			s_s2 <= s_s1;
			c_s2 <= c_s1;

			// sums already hold this word's update here
			rs_s3 <= fhe_pkg::PROD_W'(sine_sum_q) * fhe_pkg::PROD_W'(s_s2);
			rc_s3 <= fhe_pkg::PROD_W'(cosine_sum_q) * fhe_pkg::PROD_W'(c_s2);
			x_s3 <= x_s2;

			neg_s4 <= t_val[fhe_pkg::T_W-1];
			u_s4 <= t_val[fhe_pkg::U_W-1:0] ^ {fhe_pkg::U_W{t_val[fhe_pkg::T_W-1]}};
			x_s4 <= x_s3;

			// reciprocal multiply stands in for the divide by window length
			dprod_s5 <= fhe_pkg::MUL_W'(u_s4) * fhe_pkg::MUL_W'(fhe_pkg::DIV_M);
			neg_s5 <= neg_s4;
			x_s5 <= x_s4;

			harmonic_ref_q <= fhe_pkg::sat_sample(harm);
			fundamental_q <= fhe_pkg::sat_sample(fhe_pkg::H_W'(fund));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			out_valid_q <= 1'b0;
			sine_sum_q <= '0;
			cosine_sum_q <= '0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			out_valid_q <= valid_s5;
			if (valid_s1) begin
				sine_sum_q <= sine_sum_q + fhe_pkg::SUM_W'(upd_s_s1);
				cosine_sum_q <= cosine_sum_q + fhe_pkg::SUM_W'(upd_c_s1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign harmonic_ref = harmonic_ref_q;
	assign fundamental = fundamental_q;

endmodule

/* hw/rtl/fundamental_harmonic_extractor.sv */
// path: front-end register, queue, back-end stages s1 to s5, then the output register
// throughput: one word per cycle unless out_ready stalls, set by the single-port
//   sample ring in the front end and the six-stage multiply pipeline of the back end
// reset clears control state and sums; the ring is not swept, a first-pass flag
//   makes unwritten entries read as zero, so input is taken right after reset
module fundamental_harmonic_extractor (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [fhe_pkg::SAMPLE_BITS-1:0] sample,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [fhe_pkg::SAMPLE_BITS-1:0] harmonic_ref,
	output logic signed [fhe_pkg::SAMPLE_BITS-1:0] fundamental
);

	logic push;
	logic q_full;
	logic q_empty;
	logic pop;
	fhe_pkg::work_t push_data;
	fhe_pkg::work_t head;

	fhe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	fhe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	fhe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.harmonic_ref(harmonic_ref),
		.fundamental (fundamental)
	);

endmodule

/* tb/testbench.sv */
// self-checking testbench for the fundamental extractor: directed extremes, then waveform runs
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [fhe_pkg::SAMPLE_BITS-1:0] harm;
		logic signed [fhe_pkg::SAMPLE_BITS-1:0] fund;
	} split_t;

	typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_TONE} wave_e;

	// tracks ring, dft sums and the expected split of each sample into fundamental and rest
	class harmonic_checker;
		int sin_tab[fhe_pkg::WINDOW_LEN];
		int cos_tab[fhe_pkg::WINDOW_LEN];
		longint ring[fhe_pkg::WINDOW_LEN];
		int wr_pos;
		longint sin_acc;
		longint cos_acc;
		split_t due[$];
		int errors;
		int shown;
		int checked;

		function new();
			for (int k = 0; k < fhe_pkg::WINDOW_LEN; k++) begin
				fold_entry(k);
				ring[k] = 0;
			end
			wr_pos = 0;
			sin_acc = 0;
			cos_acc = 0;
			errors = 0;
			shown = 0;
			checked = 0;
		endfunction

		function longint unsigned taylor_q30(longint unsigned x, bit odd);
			longint unsigned x2;
			longint unsigned term;
			longint unsigned k;
			longint acc;
			x2 = (x * x) >> 30;
			term = odd ? x : (64'd1 << 30);
			acc = term;
			for (int n = 1; n <= 8; n++) begin
				k = odd ? 2 * n : 2 * n - 1;
				term = ((term * x2) >> 30) / (k * (k + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			return acc;
		endfunction

		function int round_to_q15(longint unsigned v);
			longint unsigned r;
			r = (v + 16384) >> 15;
			if (r > 32767) begin
				r = 32767;
			end
			return int'(r);
		endfunction

		// quarter-wave folding of the table index
		function void fold_entry(int k);
			longint unsigned r4;
			longint unsigned quad;
			longint unsigned rem;
			longint unsigned ang;
			int s;
			int c;
			r4 = 4 * k;
			quad = r4 / fhe_pkg::WINDOW_LEN;
			rem = r4 % fhe_pkg::WINDOW_LEN;
			ang = fhe_pkg::HALF_PI_Q30 * rem / fhe_pkg::WINDOW_LEN;
			s = round_to_q15(taylor_q30(ang, 1'b1));
			c = round_to_q15(taylor_q30(ang, 1'b0));
			case (quad[1:0])
				2'd0: begin
					sin_tab[k] = s;
					cos_tab[k] = c;
				end
				2'd1: begin
					sin_tab[k] = c;
					cos_tab[k] = -s;
				end
				2'd2: begin
					sin_tab[k] = -s;
					cos_tab[k] = -c;
				end
				default: begin
					sin_tab[k] = -c;
					cos_tab[k] = s;
				end
			endcase
		endfunction

		function logic signed [fhe_pkg::SAMPLE_BITS-1:0] clip(longint v);
			if (v > fhe_pkg::SAT_HI) begin
				return fhe_pkg::SAMPLE_BITS'(fhe_pkg::SAT_HI);
			end
			if (v < -fhe_pkg::SAT_HI - 1) begin
				return fhe_pkg::SAMPLE_BITS'(-fhe_pkg::SAT_HI - 1);
			end
			return fhe_pkg::SAMPLE_BITS'(v);
		endfunction

		function void take_sample(logic signed [fhe_pkg::SAMPLE_BITS-1:0] v);
			longint x;
			longint diff;
			longint num;
			longint d;
			longint t;
			longint fund;
			int s;
			int c;
			split_t e;
			x = v;
			s = sin_tab[wr_pos];
			c = cos_tab[wr_pos];
			diff = x - ring[wr_pos];
			sin_acc = sin_acc + diff * s;
			cos_acc = cos_acc + diff * c;
			ring[wr_pos] = x;
			// round half up of num / (n * 2^29), with floor division
			num = sin_acc * s + cos_acc * c;
			d = longint'(fhe_pkg::WINDOW_LEN) << 29;
			t = num + d / 2;
			fund = t / d;
			if (t % d != 0 && t < 0) begin
				fund = fund - 1;
			end
			e.harm = clip(x - fund);
			e.fund = clip(fund);
			due.push_back(e);
			wr_pos = (wr_pos + 1 == fhe_pkg::WINDOW_LEN) ? 0 : wr_pos + 1;
		endfunction

		function void check_word(logic signed [fhe_pkg::SAMPLE_BITS-1:0] h,
			logic signed [fhe_pkg::SAMPLE_BITS-1:0] f);
			split_t e;
			if (due.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected word: harmonic_ref %0d fundamental %0d", h, f);
				end
				return;
			end
			e = due.pop_front();
			if (h !== e.harm || f !== e.fund) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display({"mismatch at word %0d: harmonic_ref %0d (exp %0d) ",
						"fundamental %0d (exp %0d)"},
						checked, h, e.harm, f, e.fund);
				end
			end
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] harmonic_ref;
	logic signed [fhe_pkg::SAMPLE_BITS-1:0] fundamental;

	harmonic_checker sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;
	int cycle_count = 0;

	fundamental_harmonic_extractor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.harmonic_ref(harmonic_ref),
		.fundamental(fundamental)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_word(harmonic_ref, fundamental);
		end
	end

	task automatic send_sample(logic signed [fhe_pkg::SAMPLE_BITS-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.take_sample(v);
	endtask

	function automatic logic signed [fhe_pkg::SAMPLE_BITS-1:0] wave_value(wave_e kind, int k,
		int amp, int order, int hamp);
		longint v;
		case (kind)
			WAVE_SQUARE: v = ((k % fhe_pkg::WINDOW_LEN) < fhe_pkg::WINDOW_LEN / 2) ? amp : -amp;
			WAVE_TONE: v = (longint'(amp) * sb.sin_tab[k % fhe_pkg::WINDOW_LEN]
				+ longint'(hamp) * sb.sin_tab[(k * order) % fhe_pkg::WINDOW_LEN]) / 32768
				+ longint'($urandom_range(64)) - 32;
			default: v = longint'($urandom_range(65535)) - 32768;
		endcase
		return sb.clip(v);
	endfunction

	task automatic run_segment(wave_e kind, int count, int amp);
		int start;
		int order;
		int hamp;
		start = $urandom_range(fhe_pkg::WINDOW_LEN - 1);
		order = $urandom_range(13, 2);
		hamp = $urandom_range(amp / 2);
		for (int k = 0; k < count; k++) begin
			send_sample(wave_value(kind, start + k, amp, order, hamp));
		end
	endtask

	task automatic run_random(int count);
		int len;
		while (count > 0) begin
			len = $urandom_range(150, 20);
			if (len > count) begin
				len = count;
			end
			run_segment(wave_e'($urandom_range(2)), len, $urandom_range(32767));
			count = count - len;
		end
	endtask

	initial begin
		logic signed [fhe_pkg::SAMPLE_BITS-1:0] corner[$];
		sb = new();
		corner = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd1,
			-16'sd1, 16'sh5555, 16'shaaaa, 16'sd0, 16'sd12345, -16'sd12345};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 23;
		rx_idle_pct = 45;
		foreach (corner[i]) begin
			send_sample(corner[i]);
		end
		// full-scale square wave drives the fundamental past the output range
		run_segment(WAVE_SQUARE, 420, 32767);
		run_random(90);

		tx_idle_pct = 45;
		rx_idle_pct = 23;
		run_random(300);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// hold the output long enough for the input side to back up
		rx_hold = 300;
		run_segment(WAVE_NOISE, 40, 0);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0) begin
			@(negedge clk);
		end
		run_random(240);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
